### hdl/lwg_pkg.sv
// Package for the linear waypoint generator.
// Holds the transaction payload types, command codes and default constants.
// No dependencies.
package lwg_pkg;

  localparam int unsigned MAX_STEPS_DEF = 65535;
  localparam logic [19:0] STEP_LEN_RST  = 20'd3277;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } lwg_in_t;

  typedef struct packed {
    logic signed [31:0] way_x;
    logic signed [31:0] way_y;
    logic signed [31:0] way_z;
    logic [15:0]        step_index;
    logic               last;
    logic               clipped;
  } lwg_out_t;

endpackage

### hdl/linear_waypoint_generator_unit.sv
// Linear waypoint generator, top level.
// Depends on lwg_pkg for payload types and constants.
//
// Input channel (in_valid, in_stall, in_data): a move transaction (cmd 0) gives
// start and end points; a tick transaction (cmd 1) asks for the next waypoint.
// Output channel (out_valid, out_stall, out_data): one waypoint per move, one
// per tick while waypoints remain; a tick after the last waypoint or while
// idle gives nothing. cfg_wen/cfg_wdata write step_length (zero acts as one).
// One transaction is worked at a time by a shared 33x33 multiplier, a
// bit-serial square root (33 steps) and a bit-serial divider (49 steps).
// After acceptance a move holds in_stall through a multiply and add per axis,
// the root, the divider setup and division, a post step and the output step;
// a tick through a multiply, a division and an add for each axis in turn, then
// the output step. The waypoint enters the output register in the output step
// once that register is free. A tick with no result leaves the unit idle.
// in_stall is high while a transaction is being worked or its result waits
// for the output register. The output register holds its waypoint while
// out_stall is high; the next transaction is accepted meanwhile.
// Synchronous reset clears the plan to idle and step_length to 3277.
module linear_waypoint_generator_unit #(
  parameter int unsigned MAX_STEPS = lwg_pkg::MAX_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lwg_pkg::lwg_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lwg_pkg::lwg_out_t out_data,
  input  logic             cfg_wen,
  input  logic [19:0]      cfg_wdata
);
  import lwg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_POST = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  localparam logic [5:0] CNT_DIV_SETUP = 6'd63;

  state_t state;
  logic [19:0] step_length;
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic signed [32:0] span_x, span_y, span_z;
  logic [15:0] total_steps, current_step, idx;
  logic busy, was_clipped, is_move;
  logic [1:0] axis;
  logic [5:0] cnt;
  logic [65:0] prod, acc, rad;
  logic [32:0] root;
  logic [34:0] rem;
  logic [48:0] dvd;
  logic [19:0] drem, dvs;
  lwg_out_t res;

  logic signed [32:0] span_sel;
  logic [32:0] mag_sel, opb;
  logic [65:0] mul_out;
  logic [35:0] rsh, trial;
  logic [20:0] dsh, ddiff;
  logic [33:0] rceil;
  logic [19:0] s_eff;
  logic [32:0] offs;
  logic [31:0] org_sel, way_new;
  logic out_free;

  always_comb begin
    case (axis)
      2'd0: begin span_sel = span_x; org_sel = origin_x; end
      2'd1: begin span_sel = span_y; org_sel = origin_y; end
      default: begin span_sel = span_z; org_sel = origin_z; end
    endcase
    mag_sel = span_sel[32] ? 33'(-span_sel) : 33'(span_sel);
    opb     = is_move ? mag_sel : {17'd0, idx};
    mul_out = {33'd0, mag_sel} * {33'd0, opb};
    rsh     = {rem[33:0], rad[65:64]};
    trial   = {1'b0, root, 2'b01};
    dsh     = {drem, dvd[48]};
    ddiff   = dsh - {1'b0, dvs};
    rceil   = {1'b0, root} + {33'd0, (rem != 35'd0)};
    s_eff   = (step_length == 20'd0) ? 20'd1 : step_length;
    offs    = span_sel[32] ? 33'(-{1'b0, dvd[31:0]}) : {1'b0, dvd[31:0]};
    way_new = org_sel + offs[31:0];
    out_free = !out_valid || !out_stall;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_length  <= STEP_LEN_RST;
      origin_x     <= '0; origin_y <= '0; origin_z <= '0;
      span_x       <= '0; span_y <= '0; span_z <= '0;
      total_steps  <= '0;
      current_step <= '0;
      busy         <= 1'b0;
      was_clipped  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) step_length <= cfg_wdata;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis <= 2'd0;
            if (in_data.cmd == CMD_MOVE) begin
              is_move  <= 1'b1;
              origin_x <= in_data.start_x;
              origin_y <= in_data.start_y;
              origin_z <= in_data.start_z;
              span_x   <= 33'(in_data.end_x) - 33'(in_data.start_x);
              span_y   <= 33'(in_data.end_y) - 33'(in_data.start_y);
              span_z   <= 33'(in_data.end_z) - 33'(in_data.start_z);
              acc      <= '0;
              state    <= S_MUL;
            end else if (!busy || current_step >= total_steps || total_steps == 16'd0) begin
              busy <= 1'b0;
            end else begin
              is_move <= 1'b0;
              idx     <= current_step + 16'd1;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= mul_out;
          state <= is_move ? S_ACC : S_DIV;
          dvd   <= mul_out[48:0];
          drem  <= '0;
          dvs   <= {4'd0, total_steps};
          cnt   <= '0;
        end
        S_ACC: begin
          if (axis == 2'd2) begin
            rad   <= acc + prod;
            root  <= '0;
            rem   <= '0;
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            acc   <= acc + prod;
            axis  <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_ROOT: begin
          rad <= {rad[63:0], 2'b00};
          if (rsh >= trial) begin
            rem  <= 35'(rsh - trial);
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rsh[34:0];
            root <= {root[31:0], 1'b0};
          end
          if (cnt == 6'd32) begin
            cnt   <= CNT_DIV_SETUP;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          if (cnt == CNT_DIV_SETUP && is_move) begin
            dvd  <= 49'({15'd0, rceil} + {29'd0, s_eff} - 49'd1);
            dvs  <= s_eff;
            drem <= '0;
            cnt  <= '0;
          end else begin
            if (!ddiff[20]) begin
              drem <= ddiff[19:0];
              dvd  <= {dvd[47:0], 1'b1};
            end else begin
              drem <= dsh[19:0];
              dvd  <= {dvd[47:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd48) state <= S_POST;
          end
        end
        S_POST: begin
          if (is_move) begin
            if (dvd > 49'(MAX_STEPS)) begin
              total_steps <= 16'(MAX_STEPS);
              was_clipped <= 1'b1;
              busy        <= 1'b1;
              res.last    <= 1'b0;
              res.clipped <= 1'b1;
            end else begin
              total_steps <= dvd[15:0];
              was_clipped <= 1'b0;
              busy        <= (dvd[15:0] != 16'd0);
              res.last    <= (dvd[15:0] == 16'd0);
              res.clipped <= 1'b0;
            end
            current_step   <= '0;
            res.way_x      <= origin_x;
            res.way_y      <= origin_y;
            res.way_z      <= origin_z;
            res.step_index <= '0;
            state          <= S_FIN;
          end else begin
            case (axis)
              2'd0: res.way_x <= way_new;
              2'd1: res.way_y <= way_new;
              default: res.way_z <= way_new;
            endcase
            if (axis == 2'd2) begin
              current_step   <= idx;
              busy           <= (idx != total_steps);
              res.step_index <= idx;
              res.last       <= (idx == total_steps);
              res.clipped    <= was_clipped;
              state          <= S_FIN;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (total_steps != 16'd0)) else $error("busy with zero step count");
  a_busy_room: assert property (@(posedge clk) disable iff (rst)
    busy |-> (current_step < total_steps)) else $error("busy past last waypoint");
  a_root_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> (cnt <= 6'd32)) else $error("root counter overrun");
  a_clip_max: assert property (@(posedge clk) disable iff (rst)
    was_clipped |-> (total_steps == 16'(MAX_STEPS))) else $error("clip without saturation");
endmodule
